>>> hw/rtl/bpf_pkg.sv
// Shared constants, register codes and types of the beam prune filter.
package bpf_pkg;

  localparam int VOCAB_SIZE = 256;
  localparam int MAX_HYPS   = 1024;

  localparam int SCORE_W   = 32;
  localparam int WORD_W    = 8;
  localparam int PARENT_W  = 10;
  localparam int CORRECT_W = 9;
  localparam int RANK_W    = 18;
  localparam int KEPT_W    = 11;
  localparam int MARGIN_W  = 31;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;

  localparam int WCNT_W = 11;
  localparam int PCNT_W = 9;

  // Parent counters are packed four to a memory row.
  localparam int PLANES   = 4;
  localparam int PLANE_W  = $clog2(PLANES);
  localparam int PROWS    = MAX_HYPS / PLANES;
  localparam int PROW_W   = $clog2(PROWS);
  localparam int WADDR_W  = $clog2(VOCAB_SIZE);

  localparam logic [RANK_W-1:0] RANK_MAX = '1;
  localparam logic [KEPT_W-1:0] KEPT_MAX = '1;

  localparam logic [10:0] HIST_LIMIT_RST  = 11'd1024;
  localparam logic [30:0] MARGIN_RST      = 31'h7FFF_FFFF;
  localparam logic [10:0] MIN_KEEP_RST    = 11'd0;
  localparam logic [10:0] WORD_CAP_RST    = 11'd1024;
  localparam logic [8:0]  PARENT_CAP_RST  = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIST_LIMIT   = 3'd0,
    REG_SCORE_MARGIN = 3'd1,
    REG_MIN_KEEP     = 3'd2,
    REG_WORD_CAP     = 3'd3,
    REG_PARENT_CAP   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [10:0]         hist_limit;
    logic [MARGIN_W-1:0] score_margin;
    logic [10:0]         min_keep;
    logic [10:0]         word_cap;
    logic [8:0]          parent_cap;
  } cfg_t;

  // Control of one counter memory: read for a new item, increment the
  // entry of the item in flight, and wipe the whole level.
  typedef struct packed {
    logic rd_en;
    logic bump;
    logic clear;
  } mem_ctl_t;

endpackage

>>> hw/rtl/bpf_item_if.sv
// Input channel carrying one expanded hypothesis head per transfer.
interface bpf_item_if;
  logic                                valid;
  logic                                ready;
  logic signed [bpf_pkg::SCORE_W-1:0]  score;
  logic [bpf_pkg::WORD_W-1:0]          plain_word;
  logic [bpf_pkg::PARENT_W-1:0]        parent;
  logic [bpf_pkg::CORRECT_W-1:0]       correct_count;
  logic                                last_of_level;

  modport source (output valid, score, plain_word, parent, correct_count, last_of_level,
                  input ready);
  modport sink (input valid, score, plain_word, parent, correct_count, last_of_level,
                output ready);
endinterface

>>> hw/rtl/bpf_result_if.sv
// Output channel carrying one pruning decision per transfer.
interface bpf_result_if;
  logic                           valid;
  logic                           ready;
  logic                           keep;
  logic [bpf_pkg::RANK_W-1:0]     position;
  logic                           level_done;
  logic [bpf_pkg::KEPT_W-1:0]     survivor_total;
  logic [bpf_pkg::RANK_W-1:0]     best_correct_position;
  logic [bpf_pkg::CORRECT_W-1:0]  best_correct_count;

  modport source (output valid, keep, position, level_done, survivor_total,
                  best_correct_position, best_correct_count, input ready);
  modport sink (input valid, keep, position, level_done, survivor_total,
                best_correct_position, best_correct_count, output ready);
endinterface

>>> hw/rtl/bpf_cfg_regs.sv
// Configuration register file of the beam prune filter.
module bpf_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [bpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpf_pkg::CFG_W-1:0]       cfg_data,
  output bpf_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hist_limit   <= bpf_pkg::HIST_LIMIT_RST;
      cfg.score_margin <= bpf_pkg::MARGIN_RST;
      cfg.min_keep     <= bpf_pkg::MIN_KEEP_RST;
      cfg.word_cap     <= bpf_pkg::WORD_CAP_RST;
      cfg.parent_cap   <= bpf_pkg::PARENT_CAP_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        bpf_pkg::REG_HIST_LIMIT:   cfg.hist_limit   <= cfg_data[10:0];
        bpf_pkg::REG_SCORE_MARGIN: cfg.score_margin <= cfg_data[bpf_pkg::MARGIN_W-1:0];
        bpf_pkg::REG_MIN_KEEP:     cfg.min_keep     <= cfg_data[10:0];
        bpf_pkg::REG_WORD_CAP:     cfg.word_cap     <= cfg_data[10:0];
        bpf_pkg::REG_PARENT_CAP:   cfg.parent_cap   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/bpf_word_cnt.sv
// Per-word survivor counters: one memory entry per plain word with valid bits.
module bpf_word_cnt (
  input  logic                          clk,
  input  logic                          rst,
  input  bpf_pkg::mem_ctl_t             ctl,
  input  logic [bpf_pkg::WADDR_W-1:0]   rd_addr,
  output logic [bpf_pkg::WCNT_W-1:0]    cnt
);

  logic [bpf_pkg::WCNT_W-1:0]   mem [bpf_pkg::VOCAB_SIZE];
  logic [bpf_pkg::VOCAB_SIZE-1:0] valid;
  logic [bpf_pkg::WADDR_W-1:0]  addr_q;
  logic [bpf_pkg::WCNT_W-1:0]   rdata;
  logic [bpf_pkg::WCNT_W-1:0]   fwd;
  logic                         hit;
  logic [bpf_pkg::WCNT_W-1:0]   cnt_next;

  assign cnt      = hit ? fwd : (valid[addr_q] ? rdata : '0);
  assign cnt_next = cnt + 1'b1;

  always_ff @(posedge clk) begin
    if (ctl.bump) begin
      mem[addr_q] <= cnt_next;
    end
    if (ctl.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // A read issued in the same cycle as a write to the same entry sees the
  // old memory word, so the new count is carried alongside it.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_q <= '0;
      hit    <= 1'b0;
    end else if (ctl.rd_en) begin
      addr_q <= rd_addr;
      hit    <= ctl.bump && !ctl.clear && (addr_q == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      fwd <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= '0;
    end else if (ctl.bump) begin
      valid[addr_q] <= 1'b1;
    end
  end

endmodule

>>> hw/rtl/bpf_parent_cnt.sv
// Per-parent survivor counters: four counters per memory row, one valid bit per row.
module bpf_parent_cnt (
  input  logic                           clk,
  input  logic                           rst,
  input  bpf_pkg::mem_ctl_t              ctl,
  input  logic [bpf_pkg::PARENT_W-1:0]   rd_addr,
  output logic [bpf_pkg::PCNT_W-1:0]     cnt
);

  typedef logic [bpf_pkg::PLANES-1:0][bpf_pkg::PCNT_W-1:0] prow_t;

  prow_t                          mem [bpf_pkg::PROWS];
  logic [bpf_pkg::PROWS-1:0]      valid;
  logic [bpf_pkg::PROW_W-1:0]     row_q;
  logic [bpf_pkg::PLANE_W-1:0]    lane_q;
  logic [bpf_pkg::PROW_W-1:0]     rd_row;
  logic [bpf_pkg::PLANE_W-1:0]    rd_lane;
  prow_t                          rdata;
  prow_t                          fwd;
  prow_t                          row_eff;
  prow_t                          row_next;
  logic                           hit;

  assign rd_row  = rd_addr[bpf_pkg::PARENT_W-1:bpf_pkg::PLANE_W];
  assign rd_lane = rd_addr[bpf_pkg::PLANE_W-1:0];

  assign row_eff = hit ? fwd : (valid[row_q] ? rdata : '0);
  assign cnt     = row_eff[lane_q];

  always_comb begin
    row_next         = row_eff;
    row_next[lane_q] = cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (ctl.bump) begin
      mem[row_q] <= row_next;
    end
    if (ctl.rd_en) begin
      rdata <= mem[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_q  <= '0;
      lane_q <= '0;
      hit    <= 1'b0;
    end else if (ctl.rd_en) begin
      row_q  <= rd_row;
      lane_q <= rd_lane;
      hit    <= ctl.bump && !ctl.clear && (row_q == rd_row);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      fwd <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= '0;
    end else if (ctl.bump) begin
      valid[row_q] <= 1'b1;
    end
  end

endmodule

>>> hw/rtl/beam_prune_filter_unit.sv
// Beam prune filter top level: decision stage, counter memories and result register.
// Pipeline: the counter memory reads and the decision stage, then the result register.
// Throughput: one item per cycle unless the consumer stalls; the word and parent counter
// memories each take one read and one write per cycle, with forwarding between neighboring
// items. Reset (rst, synchronous): config returns to defaults, level state and all counter
// valid bits clear; no clearing pass is needed.
module beam_prune_filter_unit (
  input  logic                           clk,
  input  logic                           rst,
  bpf_item_if.sink                       item,
  bpf_result_if.source                   result,
  input  logic                           cfg_write,
  input  logic [bpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpf_pkg::CFG_W-1:0]      cfg_data
);

  bpf_pkg::cfg_t     cfg;
  bpf_pkg::mem_ctl_t word_ctl;
  bpf_pkg::mem_ctl_t parent_ctl;

  logic [bpf_pkg::WCNT_W-1:0] word_cnt;
  logic [bpf_pkg::PCNT_W-1:0] parent_cnt;

  // Decision stage: the item whose counter reads are under way.
  logic                                s1_valid;
  logic signed [bpf_pkg::SCORE_W-1:0]  s1_score;
  logic [bpf_pkg::CORRECT_W-1:0]       s1_correct;
  logic                                s1_last;

  // Level state.
  logic signed [bpf_pkg::SCORE_W-1:0]  level_best;
  logic [bpf_pkg::RANK_W-1:0]          item_rank;
  logic [bpf_pkg::KEPT_W-1:0]          kept_count;
  logic [bpf_pkg::CORRECT_W-1:0]       top_correct;
  logic [bpf_pkg::RANK_W-1:0]          top_rank;

  logic                                out_valid;
  logic                                out_free;
  logic                                fire;
  logic                                take;

  logic signed [bpf_pkg::SCORE_W-1:0]  best;
  logic signed [bpf_pkg::SCORE_W+1:0]  threshold;
  logic signed [bpf_pkg::SCORE_W+1:0]  score_wide;
  logic                                score_ok;
  logic                                rank_ok;
  logic                                keep;
  logic [bpf_pkg::KEPT_W-1:0]          kept_next;
  logic                                top_move;
  logic [bpf_pkg::CORRECT_W-1:0]       top_correct_next;
  logic [bpf_pkg::RANK_W-1:0]          top_rank_next;

  bpf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The output register frees as its result transfers, so the decision stage
  // and the input keep moving every cycle unless the consumer stalls. No
  // transfer is taken while reset is held.
  assign out_free   = !out_valid || result.ready;
  assign fire       = s1_valid && out_free;
  assign item.ready = !rst && (!s1_valid || fire);
  assign take       = item.valid && item.ready;

  // Both memories are read when an item is taken and incremented when the
  // decision stage hands a kept item on; the last item of a level wipes them.
  always_comb begin
    word_ctl.rd_en  = take;
    word_ctl.bump   = fire && keep;
    word_ctl.clear  = fire && s1_last;
    parent_ctl      = word_ctl;
  end

  bpf_word_cnt u_word (
    .clk     (clk),
    .rst     (rst),
    .ctl     (word_ctl),
    .rd_addr (item.plain_word),
    .cnt     (word_cnt)
  );

  bpf_parent_cnt u_parent (
    .clk     (clk),
    .rst     (rst),
    .ctl     (parent_ctl),
    .rd_addr (item.parent),
    .cnt     (parent_cnt)
  );

  // The first item of a level sets the level best score. The margin test is
  // done two bits wider so that best minus margin cannot wrap.
  assign best       = (item_rank == '0) ? s1_score : level_best;
  assign threshold  = {{2{best[bpf_pkg::SCORE_W-1]}}, best}
                    - $signed({3'b000, cfg.score_margin});
  assign score_wide = {{2{s1_score[bpf_pkg::SCORE_W-1]}}, s1_score};
  assign score_ok   = (score_wide >= threshold)
                    || (item_rank < {7'd0, cfg.min_keep});
  assign rank_ok    = item_rank < {7'd0, cfg.hist_limit};

  assign keep = rank_ok && score_ok
             && (word_cnt < cfg.word_cap)
             && (parent_cnt < cfg.parent_cap);

  assign kept_next = (keep && kept_count != bpf_pkg::KEPT_MAX) ? kept_count + 1'b1
                                                                : kept_count;

  // Only a strictly higher correct count moves the tracked position.
  assign top_move         = s1_correct > top_correct;
  assign top_correct_next = top_move ? s1_correct : top_correct;
  assign top_rank_next    = top_move ? item_rank : top_rank;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_score   <= item.score;
      s1_correct <= item.correct_count;
      s1_last    <= item.last_of_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_best  <= '0;
      item_rank   <= '0;
      kept_count  <= '0;
      top_correct <= '0;
      top_rank    <= '0;
    end else if (fire) begin
      if (s1_last) begin
        level_best  <= '0;
        item_rank   <= '0;
        kept_count  <= '0;
        top_correct <= '0;
        top_rank    <= '0;
      end else begin
        level_best  <= best;
        kept_count  <= kept_next;
        top_correct <= top_correct_next;
        top_rank    <= top_rank_next;
        if (item_rank != bpf_pkg::RANK_MAX) begin
          item_rank <= item_rank + 1'b1;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.keep                  <= keep;
      result.position              <= item_rank;
      result.level_done            <= s1_last;
      result.survivor_total        <= kept_next;
      result.best_correct_position <= top_rank_next;
      result.best_correct_count    <= top_correct_next;
    end
  end

  assign result.valid = out_valid;

endmodule

>>> dv/beam_prune_filter_unit_tb.sv
// Self-checking testbench for the beam prune filter: directed levels and random levels.
`timescale 1ns / 1ps

module beam_prune_filter_unit_tb;
  import bpf_pkg::*;

  // One hypothesis head as it is offered on the item channel.
  typedef struct {
    logic signed [SCORE_W-1:0] score;
    logic [WORD_W-1:0]         plain_word;
    logic [PARENT_W-1:0]       parent;
    logic [CORRECT_W-1:0]      correct_count;
    logic                      last_of_level;
  } head_t;

  // One pruning decision as it leaves on the result channel.
  typedef struct {
    logic                 keep;
    logic [RANK_W-1:0]    position;
    logic                 level_done;
    logic [KEPT_W-1:0]    survivor_total;
    logic [RANK_W-1:0]    best_correct_position;
    logic [CORRECT_W-1:0] best_correct_count;
  } verdict_t;

  // Keeps its own copy of the limits and of the per-level counters. Every
  // accepted head is turned into the decision the block must make for it,
  // and those decisions are checked in order against the result channel.
  class prune_decision_board;
    logic [10:0]         hist_limit;
    logic [MARGIN_W-1:0] score_margin;
    logic [10:0]         min_keep;
    logic [10:0]         word_cap;
    logic [8:0]          parent_cap;

    logic [WCNT_W-1:0]    word_kept [VOCAB_SIZE];
    logic [PCNT_W-1:0]    parent_kept [MAX_HYPS];
    longint               level_best;
    logic [RANK_W-1:0]    next_rank;
    logic [KEPT_W-1:0]    kept_total;
    logic [CORRECT_W-1:0] top_correct;
    logic [RANK_W-1:0]    top_correct_rank;

    verdict_t expected_verdicts[$];
    int       failures;

    function new();
      hist_limit   = HIST_LIMIT_RST;
      score_margin = MARGIN_RST;
      min_keep     = MIN_KEEP_RST;
      word_cap     = WORD_CAP_RST;
      parent_cap   = PARENT_CAP_RST;
      failures     = 0;
      clear_level();
    endfunction

    function void clear_level();
      foreach (word_kept[i]) word_kept[i] = '0;
      foreach (parent_kept[i]) parent_kept[i] = '0;
      level_best       = 0;
      next_rank        = '0;
      kept_total       = '0;
      top_correct      = '0;
      top_correct_rank = '0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_HIST_LIMIT:   hist_limit   = value[10:0];
        REG_SCORE_MARGIN: score_margin = value[MARGIN_W-1:0];
        REG_MIN_KEEP:     min_keep     = value[10:0];
        REG_WORD_CAP:     word_cap     = value[10:0];
        REG_PARENT_CAP:   parent_cap   = value[8:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    function void note_head(head_t h);
      logic [RANK_W-1:0] rank;
      longint            score_l;
      longint            margin_l;
      bit                word_ok;
      bit                parent_ok;
      bit                kept;
      verdict_t          v;
      rank     = next_rank;
      score_l  = longint'(h.score);
      margin_l = longint'(score_margin);
      if (rank == 0) begin
        level_best = score_l;
      end
      // Only a strictly higher count moves the tracked position.
      if (h.correct_count > top_correct) begin
        top_correct      = h.correct_count;
        top_correct_rank = rank;
      end
      // Word and parent fields cannot exceed the table sizes at these widths.
      word_ok   = word_kept[h.plain_word] < word_cap;
      parent_ok = parent_kept[h.parent] < parent_cap;
      kept = (rank < hist_limit)
          && ((score_l >= level_best - margin_l) || (rank < min_keep))
          && word_ok && parent_ok;
      if (kept) begin
        word_kept[h.plain_word] = word_kept[h.plain_word] + 1'b1;
        parent_kept[h.parent]   = parent_kept[h.parent] + 1'b1;
        if (kept_total != KEPT_MAX) kept_total = kept_total + 1'b1;
      end
      v.keep                  = kept;
      v.position              = rank;
      v.level_done            = h.last_of_level;
      v.survivor_total        = kept_total;
      v.best_correct_position = top_correct_rank;
      v.best_correct_count    = top_correct;
      expected_verdicts = {expected_verdicts, v};
      if (h.last_of_level) begin
        clear_level();
      end else if (next_rank != RANK_MAX) begin
        next_rank = next_rank + 1'b1;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        $error("result at position %0d with no head outstanding", got.position);
        failures++;
        return;
      end
      want = expected_verdicts.pop_front();
      compare_field("keep", 32'(want.keep), 32'(got.keep));
      compare_field("position", 32'(want.position), 32'(got.position));
      compare_field("level_done", 32'(want.level_done), 32'(got.level_done));
      compare_field("survivor_total", 32'(want.survivor_total), 32'(got.survivor_total));
      compare_field("best_correct_position", 32'(want.best_correct_position),
                    32'(got.best_correct_position));
      compare_field("best_correct_count", 32'(want.best_correct_count),
                    32'(got.best_correct_count));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  bpf_item_if   item_ch ();
  bpf_result_if result_ch ();

  beam_prune_filter_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  prune_decision_board board;

  // Percentages of cycles in which the sender or the receiver sits idle.
  int tx_idle_pct;
  int rx_idle_pct;
  // Set by the main sequence to make the receiver hold off for a long stretch.
  bit stall_request;
  int stall_left;

  verdict_t seen_verdict;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // The receiver decides its ready at every falling edge. A requested
  // hold-off is counted down here, cycle by cycle, while the sender keeps
  // offering heads so that the pipeline fills and the input stalls.
  initial begin
    bit stall_served;
    stall_served    = 1'b0;
    stall_left      = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request && !stall_served) begin
        stall_served = 1'b1;
        stall_left   = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Every result transfer is checked against the oldest expected decision.
  always @(posedge clk) begin
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      seen_verdict.keep                  = result_ch.keep;
      seen_verdict.position              = result_ch.position;
      seen_verdict.level_done            = result_ch.level_done;
      seen_verdict.survivor_total        = result_ch.survivor_total;
      seen_verdict.best_correct_position = result_ch.best_correct_position;
      seen_verdict.best_correct_count    = result_ch.best_correct_count;
      board.check_verdict(seen_verdict);
    end
  end

  // Offers one head from a falling edge and returns at the rising edge of its
  // transfer. Valid stays high on return, so back-to-back heads never drop it;
  // whoever stops sending lowers it at the next falling edge.
  task automatic send_head(logic signed [SCORE_W-1:0] score, logic [WORD_W-1:0] word,
                           logic [PARENT_W-1:0] parent, logic [CORRECT_W-1:0] correct,
                           logic last);
    head_t h;
    h.score         = score;
    h.plain_word    = word;
    h.parent        = parent;
    h.correct_count = correct;
    h.last_of_level = last;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.score         <= h.score;
    item_ch.plain_word    <= h.plain_word;
    item_ch.parent        <= h.parent;
    item_ch.correct_count <= h.correct_count;
    item_ch.last_of_level <= h.last_of_level;
    @(posedge clk);
    while (item_ch.ready !== 1'b1) @(posedge clk);
    board.note_head(h);
  endtask

  // Stops offering, then waits until every outstanding decision has left the pipeline, so
  // that the block is idle before a register write.
  task automatic wait_idle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    board.set_reg(idx, value);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_limits(int hist, int margin, int keep_n, int wcap, int pcap);
    wait_idle();
    write_reg(REG_HIST_LIMIT, CFG_W'(hist));
    write_reg(REG_SCORE_MARGIN, CFG_W'(margin));
    write_reg(REG_MIN_KEEP, CFG_W'(keep_n));
    write_reg(REG_WORD_CAP, CFG_W'(wcap));
    write_reg(REG_PARENT_CAP, CFG_W'(pcap));
  endtask

  // Mostly small limits so that every test of the filter bites, with the
  // register extremes mixed in.
  task automatic randomize_limits();
    int hist;
    int margin;
    int keep_n;
    int wcap;
    int pcap;
    case ($urandom_range(0, 6))
      0: hist = 1;
      1: hist = 1024;
      2: hist = 2047;
      3: hist = 0;
      default: hist = $urandom_range(1, 32);
    endcase
    case ($urandom_range(0, 4))
      0: margin = 0;
      1: margin = 32'h7FFF_FFFF;
      default: margin = $urandom_range(0, 32'h0008_0000);
    endcase
    case ($urandom_range(0, 5))
      0: keep_n = 0;
      1: keep_n = 1024;
      2: keep_n = 2047;
      default: keep_n = $urandom_range(0, 12);
    endcase
    case ($urandom_range(0, 5))
      0: wcap = 1;
      1: wcap = 1024;
      2: wcap = 2047;
      default: wcap = $urandom_range(1, 6);
    endcase
    case ($urandom_range(0, 5))
      0: pcap = 1;
      1: pcap = 256;
      2: pcap = 511;
      default: pcap = $urandom_range(1, 6);
    endcase
    set_limits(hist, margin, keep_n, wcap, pcap);
  endtask

  // One level of heads. A well-formed level is sorted best first with words
  // and parents drawn from a pool sized to hit the caps; a noisy level has
  // unsorted scores from the whole 32-bit range, positive ones included.
  task automatic send_level(int len, bit noisy);
    longint               sc;
    int                   word_span;
    int                   parent_span;
    logic [CORRECT_W-1:0] correct;
    logic [SCORE_W-1:0]   raw;
    case ($urandom_range(0, 2))
      0: word_span = 3;
      1: word_span = 15;
      default: word_span = 255;
    endcase
    case ($urandom_range(0, 2))
      0: parent_span = 3;
      1: parent_span = 31;
      default: parent_span = 1023;
    endcase
    case ($urandom_range(0, 4))
      0: sc = 0;
      1: sc = -64'sd2147483648 + $urandom_range(0, 32'h0004_0000);
      2: sc = -longint'($urandom_range(0, 32'h7FFF_FFFF));
      default: sc = -longint'($urandom_range(0, 32'h0010_0000));
    endcase
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        correct = CORRECT_W'($urandom_range(0, 511));
      end else begin
        correct = CORRECT_W'($urandom_range(0, 256));
      end
      if (noisy) begin
        raw = $urandom;
      end else begin
        raw = sc[SCORE_W-1:0];
        sc  = sc - $urandom_range(0, 32'h0003_0000);
        if (sc < -64'sd2147483648) sc = -64'sd2147483648;
      end
      send_head(raw, WORD_W'($urandom_range(0, word_span)),
                PARENT_W'($urandom_range(0, parent_span)), correct, i == len - 1);
    end
  endtask

  // Main sequence: reset, directed levels, then three random phases with
  // different idling.
  initial begin
    int sent;
    int len;

    rst                     = 1'b1;
    cfg_write               = 1'b0;
    cfg_index               = '0;
    cfg_data                = '0;
    item_ch.valid           = 1'b0;
    item_ch.score           = '0;
    item_ch.plain_word      = '0;
    item_ch.parent          = '0;
    item_ch.correct_count   = '0;
    item_ch.last_of_level   = 1'b0;
    tx_idle_pct             = 0;
    rx_idle_pct             = 0;
    stall_request           = 1'b0;
    board                   = new();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Limits as they come out of reset. The most negative score falls just
    // below the widest margin, a score exactly at the floor is kept, an equal
    // correct count does not move the tracked position, and a positive score
    // and the widest correct count still go through.
    send_head(32'sh0000_0000, 8'd0, 10'd0, 9'd0, 1'b0);
    send_head(32'sh8000_0000, 8'd255, 10'd1023, 9'd256, 1'b0);
    send_head(32'shFFFF_FFFF, 8'd255, 10'd1023, 9'd256, 1'b0);
    send_head(32'sh7FFF_FFFF, 8'd0, 10'd0, 9'd511, 1'b0);
    send_head(-32'sh7FFF_FFFF, 8'd1, 10'd1, 9'd0, 1'b1);
    // A level of one head, all correct counts zero.
    send_head(32'sh8000_0000, 8'd7, 10'd5, 9'd0, 1'b1);

    // Tight limits: one unit of margin, two forced keeps, one head per word,
    // two per parent and four positions in all.
    set_limits(4, 32'h0001_0000, 2, 1, 2);
    send_head(-32'sd131072, 8'd3, 10'd9, 9'd5, 1'b0);
    send_head(-32'sd655360, 8'd3, 10'd9, 9'd5, 1'b0);
    send_head(-32'sd655360, 8'd4, 10'd9, 9'd5, 1'b0);
    send_head(-32'sd196608, 8'd5, 10'd9, 9'd9, 1'b0);
    send_head(-32'sd131072, 8'd6, 10'd9, 9'd9, 1'b0);
    send_head(-32'sd131072, 8'd7, 10'd10, 9'd1, 1'b0);
    send_head(32'sh0000_0000, 8'd8, 10'd11, 9'd0, 1'b1);

    // Zero limits keep nothing.
    set_limits(0, 0, 0, 1, 1);
    send_head(32'sh0000_0000, 8'd0, 10'd0, 9'd3, 1'b0);
    send_head(32'sh0000_0000, 8'd1, 10'd1, 9'd4, 1'b1);
    set_limits(2047, 32'h7FFF_FFFF, 2047, 0, 511);
    send_head(32'sh0000_0000, 8'd2, 10'd2, 9'd0, 1'b1);
    set_limits(2047, 32'h7FFF_FFFF, 2047, 2047, 0);
    send_head(32'sh0000_0000, 8'd2, 10'd2, 9'd0, 1'b1);

    // Random phases: sender lightly idle and receiver heavily idle, then the
    // reverse, then no idling at all. The first phase also carries the long
    // receiver hold-off.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 28;
          rx_idle_pct = 56;
        end
        1: begin
          tx_idle_pct = 56;
          rx_idle_pct = 28;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int sub = 0; sub < 2; sub++) begin
        randomize_limits();
        if (phase == 0 && sub == 0) stall_request = 1'b1;
        sent = 0;
        while (sent < 175) begin
          if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(40, 200);
          end else begin
            len = $urandom_range(1, 24);
          end
          send_level(len, $urandom_range(0, 9) == 0);
          sent += len;
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
